@@ rtl/core/mset_pkg.sv @@
// ----------------------------------------------------------------------------
// mset_pkg: shared types and constants for the multi-slot event timer
// Sizes, operation codes, the token that walks the cell chain and the
// firing report that a cell hands back to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mset_pkg;

    // Table size and derived widths.
    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int FREE_W      = $clog2(SLOT_COUNT + 1);
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PERIOD_W    = 32;
    localparam int OP_W        = 3;
    localparam int HANDLE_W    = 3;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH    = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE_NEXT = 3'd2;
    localparam logic [OP_W-1:0] OP_CREATE_ZERO = 3'd3;
    localparam logic [OP_W-1:0] OP_END         = 3'd4;

    // Action carried by the token through the chain.
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_TICK,
        CELL_DISPATCH,
        CELL_LOAD,
        CELL_END
    } cell_op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } ctrl_state_t;

    // Kind of closing result owed once the token leaves the chain.
    typedef enum logic [1:0] {
        RES_NONE,
        RES_DISPATCH,
        RES_CREATE
    } result_kind_t;

    // Command token handed from cell to cell, one hop per cycle unless the chain is held.
    typedef struct packed {
        logic                valid;
        cell_op_t            op;
        logic [SLOT_W-1:0]   pos;
        logic [SLOT_W-1:0]   target;
        logic [PERIOD_W-1:0] period;
        logic                act;
        logic                once;
        logic [CNT_W-1:0]    cnt;
    } token_t;

    // Firing report from the cell that holds the token.
    typedef struct packed {
        logic              fire;
        logic [SLOT_W-1:0] handle;
    } fire_evt_t;

    // Controller to chain control.
    typedef struct packed {
        logic   hold;
        token_t tok;
    } chain_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/mset_cell.sv @@
// ----------------------------------------------------------------------------
// mset_cell: one timer slot of the chain
// Holds period, remaining count and flags of one slot, applies the token
// that passes through it and forwards the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mset_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               hold,
    input  wire mset_pkg::token_t   tok_in,
    output mset_pkg::token_t        tok_out,
    output mset_pkg::fire_evt_t     evt
);
    import mset_pkg::*;

    token_t              tok_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic [PERIOD_W-1:0] remain_reg;
    logic [PERIOD_W-1:0] remain_next;
    logic                active_reg;
    logic                active_next;
    logic                once_reg;
    logic                once_next;
    logic                hit;
    logic                fire;

    // The token addresses this slot when its position matches the target.
    assign hit  = tok_reg.valid && (tok_reg.pos == tok_reg.target);
    assign fire = tok_reg.valid && (tok_reg.op == CELL_DISPATCH) && active_reg
                  && (remain_reg == '0) && (tok_reg.cnt < CNT_W'(MAX_RESULTS));

    assign evt.fire   = fire;
    assign evt.handle = fire ? tok_reg.pos : '0;

    // Forward the token with the next position and the updated fire count.
    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.pos = tok_reg.pos + SLOT_W'(1);
        tok_out.cnt = tok_reg.cnt + CNT_W'(fire);
    end

    // Apply the token to this slot.
    always_comb
    begin
        period_next = period_reg;
        remain_next = remain_reg;
        active_next = active_reg;
        once_next   = once_reg;
        if (tok_reg.valid && !hold)
        begin
            case (tok_reg.op)
                CELL_TICK:
                begin
                    if (active_reg && (remain_reg != '0))
                    begin
                        remain_next = remain_reg - PERIOD_W'(1);
                    end
                end
                CELL_DISPATCH:
                begin
                    if (fire)
                    begin
                        remain_next = period_reg;
                        if (once_reg)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                CELL_LOAD:
                begin
                    if (hit)
                    begin
                        period_next = tok_reg.period;
                        remain_next = tok_reg.period;
                        active_next = tok_reg.act;
                        once_next   = tok_reg.once;
                    end
                end
                CELL_END:
                begin
                    if (hit)
                    begin
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Slot state and token stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            period_reg <= '0;
            remain_reg <= '0;
            active_reg <= 1'b0;
            once_reg   <= 1'b0;
        end
        else
        begin
            period_reg <= period_next;
            remain_reg <= remain_next;
            active_reg <= active_next;
            once_reg   <= once_next;
            if (!hold)
            begin
                tok_reg <= tok_in;
            end
        end
    end

    // The fire count never passes the per-dispatch cap.
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid |-> (tok_reg.cnt <= CNT_W'(MAX_RESULTS)))
        else $error("token fire count above cap");

    // A one-shot slot that fires is inactive afterwards.
    a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !hold && once_reg) |=> !active_reg)
        else $error("one-shot slot still active after firing");

    // A held chain keeps its token in place.
    a_hold_token: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(tok_reg))
        else $error("token moved during hold");

endmodule

`default_nettype wire

@@ rtl/core/mset_ctrl.sv @@
// ----------------------------------------------------------------------------
// mset_ctrl: item sequencer for the multi-slot event timer
// Accepts items, launches a token into the cell chain, orders firing
// reports into results with a one-deep pending stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mset_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mset_pkg::OP_W-1:0]     operation,
    input  wire logic [2:0]                    slot,
    input  wire logic [mset_pkg::PERIOD_W-1:0] period,
    input  wire logic                          start_active,
    input  wire logic                          one_shot,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mset_pkg::HANDLE_W-1:0]      handle,
    output logic                               fired,
    output logic                               status,
    output logic                               last,
    output mset_pkg::chain_ctl_t               ctl,
    input  wire mset_pkg::fire_evt_t           evt,
    input  wire logic                          tok_exit
);
    import mset_pkg::*;

    ctrl_state_t           state_reg;
    ctrl_state_t           state_next;
    result_kind_t          kind_reg;
    result_kind_t          kind_next;
    logic [HANDLE_W-1:0]   create_handle_reg;
    logic [HANDLE_W-1:0]   create_handle_next;
    logic                  full_reg;
    logic                  full_next;
    logic [FREE_W-1:0]     free_reg;
    logic [FREE_W-1:0]     free_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [SLOT_W-1:0]     pend_handle_reg;
    logic [SLOT_W-1:0]     pend_handle_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [HANDLE_W-1:0]   handle_next;
    logic                  fired_reg;
    logic                  fired_next;
    logic                  status_reg;
    logic                  status_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  in_accept;
    logic                  out_free;
    logic                  hold;
    logic                  exit_go;
    token_t                tok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // The chain waits when a firing meets a full pending stage and stalled output.
    assign hold    = evt.fire && pend_valid_reg && !out_free;
    assign exit_go = tok_exit && !hold;

    assign ctl.hold = hold;
    assign ctl.tok  = tok;

    assign out_valid = out_valid_reg;
    assign handle    = handle_reg;
    assign fired     = fired_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Decode an accepted item into a chain token and the result it owes.
    always_comb
    begin
        tok                = '0;
        tok.valid          = in_accept;
        tok.period         = period;
        tok.act            = start_active;
        tok.once           = one_shot;
        kind_next          = kind_reg;
        create_handle_next = create_handle_reg;
        full_next          = full_reg;
        free_next          = free_reg;
        if (in_accept)
        begin
            kind_next = RES_NONE;
            full_next = 1'b0;
            unique case (operation)
                OP_TICK:
                begin
                    tok.op = CELL_TICK;
                end
                OP_DISPATCH:
                begin
                    tok.op    = CELL_DISPATCH;
                    kind_next = RES_DISPATCH;
                end
                OP_CREATE_NEXT:
                begin
                    kind_next = RES_CREATE;
                    if (free_reg >= FREE_W'(SLOT_COUNT))
                    begin
                        full_next          = 1'b1;
                        create_handle_next = '0;
                    end
                    else
                    begin
                        tok.op             = CELL_LOAD;
                        tok.target         = SLOT_W'(free_reg);
                        create_handle_next = HANDLE_W'(free_reg);
                        free_next          = free_reg + FREE_W'(1);
                    end
                end
                OP_CREATE_ZERO:
                begin
                    tok.op             = CELL_LOAD;
                    kind_next          = RES_CREATE;
                    create_handle_next = '0;
                end
                OP_END:
                begin
                    if (32'(slot) < 32'(SLOT_COUNT))
                    begin
                        tok.op     = CELL_END;
                        tok.target = SLOT_W'(slot);
                    end
                end
                default:
                begin
                    tok.op = CELL_NOP;
                end
            endcase
        end
    end

    // Sequencing, pending stage and output register.
    always_comb
    begin
        state_next       = state_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && out_stall;
        handle_next      = handle_reg;
        fired_next       = fired_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (evt.fire && !hold)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        handle_next    = HANDLE_W'(pend_handle_reg);
                        fired_next     = 1'b1;
                        status_next    = 1'b0;
                        last_next      = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_handle_next = evt.handle;
                end
                if (exit_go)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (kind_reg == RES_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (kind_reg == RES_CREATE)
                    begin
                        handle_next = create_handle_reg;
                        fired_next  = 1'b0;
                        status_next = full_reg;
                    end
                    else
                    begin
                        handle_next = pend_valid_reg ? HANDLE_W'(pend_handle_reg) : '0;
                        fired_next  = pend_valid_reg;
                        status_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= RES_NONE;
            full_reg       <= 1'b0;
            free_reg       <= FREE_W'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            full_reg       <= full_next;
            free_reg       <= free_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        create_handle_reg <= create_handle_next;
        pend_handle_reg   <= pend_handle_next;
        handle_reg        <= handle_next;
        fired_reg         <= fired_next;
        status_reg        <= status_next;
        last_reg          <= last_next;
    end

    // The chain is only held while a token is in flight.
    a_hold_run: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> (state_reg == ST_RUN))
        else $error("chain held outside run state");

    // A token leaves the chain only while the item is running.
    a_exit_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_exit |-> (state_reg == ST_RUN))
        else $error("token exit outside run state");

    // Nothing is left pending once the block is idle again.
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending firing while idle");

    // The closing result of an item carries the last mark.
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (kind_reg != RES_NONE) && out_free)
        |=> (out_valid_reg && last_reg))
        else $error("closing result without last mark");

endmodule

`default_nettype wire

@@ rtl/core/multi_slot_event_timer_core.sv @@
// ----------------------------------------------------------------------------
// multi_slot_event_timer_core: table of timer slots built as a cell chain
// A token per item walks a row of slot cells, one cell per cycle while the
// chain is not held; the controller turns firing reports into ordered results.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_stall   | operation, slot, period, start_active,
//           |                       | one_shot
//   out     | out_valid / out_stall | handle, fired, status, last
//
// An item is accepted only while the block is idle; its token is launched,
// walks the chain through every cell, and the item then closes before the next
// acceptance. While a result waits for a full, stalled output register, the
// chain or the closing step is held.
// Reset clears all slots and sets the next free slot to one.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_event_timer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mset_pkg::OP_W-1:0]     operation,
    input  wire logic [2:0]                    slot,
    input  wire logic [mset_pkg::PERIOD_W-1:0] period,
    input  wire logic                          start_active,
    input  wire logic                          one_shot,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mset_pkg::HANDLE_W-1:0]      handle,
    output logic                               fired,
    output logic                               status,
    output logic                               last
);
    import mset_pkg::*;

    chain_ctl_t ctl;
    token_t     tok_chain [SLOT_COUNT+1];
    fire_evt_t  evt_cell  [SLOT_COUNT];
    fire_evt_t  evt_any;

    assign tok_chain[0] = ctl.tok;

    // Row of slot cells, each forwarding the token to its neighbor.
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        mset_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .hold    (ctl.hold),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .evt     (evt_cell[i])
        );
    end

    // Only the cell holding the token can report, so an OR merges them.
    always_comb
    begin
        evt_any = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            evt_any = evt_any | evt_cell[i];
        end
    end

    mset_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .slot         (slot),
        .period       (period),
        .start_active (start_active),
        .one_shot     (one_shot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .handle       (handle),
        .fired        (fired),
        .status       (status),
        .last         (last),
        .ctl          (ctl),
        .evt          (evt_any),
        .tok_exit     (tok_chain[SLOT_COUNT].valid)
    );

endmodule

`default_nettype wire

@@ dv/multi_slot_event_timer_core_tb.sv @@
// ----------------------------------------------------------------------------
// multi_slot_event_timer_core_tb: self-checking bench for the timer slot table
// Drives ticks, dispatches, creates and ends through the valid/stall input
// channel and checks every result against a cycle-free model of the table.
// A short directed table covers the table-full reply, slot zero, zero and
// maximum periods, idle ends and reserved codes. A long random run follows,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_event_timer_core_tb;

    import mset_pkg::*;

    // Run length and pacing.
    localparam int RANDOM_ITEMS = 285;
    localparam int PAUSE_AT     = 150;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 260;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AFTER   = 60;
    localparam int TAIL_CYCLES  = 4 * (SLOT_COUNT + 2);
    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_REPORTS  = 10;

    // Reserved operation codes that the block must ignore.
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    // One result as seen on the output channel.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                fired;
        logic                status;
        logic                last;
    } timer_result_t;

    // One stimulus item, with an optional fixed expected result.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [2:0]          slot;
        logic [PERIOD_W-1:0] period;
        logic                act;
        logic                once;
        logic                has_fixed;
        timer_result_t       want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [OP_W-1:0] operation;
    logic [2:0] slot;
    logic [PERIOD_W-1:0] period;
    logic start_active;
    logic one_shot;
    logic out_valid;
    logic out_stall;
    logic [HANDLE_W-1:0] handle;
    logic fired;
    logic status;
    logic last;

    // Model of the slot table.
    logic [PERIOD_W-1:0] tbl_remaining [SLOT_COUNT];
    logic [PERIOD_W-1:0] tbl_period [SLOT_COUNT];
    logic                tbl_active [SLOT_COUNT];
    logic                tbl_once [SLOT_COUNT];
    int                  tbl_next_free;

    timer_result_t pending_results [$];
    timer_result_t fresh_results [$];
    stim_row_t     directed_rows [$];

    int cycle_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int firings_seen = 0;
    int full_seen = 0;
    int mismatch_cnt = 0;

    multi_slot_event_timer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .slot         (slot),
        .period       (period),
        .start_active (start_active),
        .one_shot     (one_shot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .handle       (handle),
        .fired        (fired),
        .status       (status),
        .last         (last)
    );

    always #2 clk = ~clk;

    function automatic timer_result_t make_result(int h, int f, int s, int l);
        timer_result_t r;
        r.handle = HANDLE_W'(h);
        r.fired  = 1'(f);
        r.status = 1'(s);
        r.last   = 1'(l);
        return r;
    endfunction

    function automatic stim_row_t stim_row(logic [OP_W-1:0] op, int slot_i,
                                           logic [PERIOD_W-1:0] period_i, int act_i,
                                           int once_i, int fixed_i, int h, int f,
                                           int s, int l);
        stim_row_t r;
        r.op        = op;
        r.slot      = 3'(slot_i);
        r.period    = period_i;
        r.act       = 1'(act_i);
        r.once      = 1'(once_i);
        r.has_fixed = 1'(fixed_i);
        r.want      = make_result(h, f, s, l);
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic load_slot_model(int s, logic [PERIOD_W-1:0] p, logic a, logic o);
        tbl_period[s]    = p;
        tbl_remaining[s] = p;
        tbl_active[s]    = a;
        tbl_once[s]      = o;
    endtask

    // Apply one item to the table model and collect the results it causes.
    task automatic advance_timer_table(stim_row_t r);
        int n;
        timer_result_t tail;
        n = 0;
        fresh_results.delete();
        case (r.op)
            OP_TICK:
            begin
                for (int s = 0; s < SLOT_COUNT; s++)
                    if (tbl_active[s] && tbl_remaining[s] != '0)
                        tbl_remaining[s] -= 1;
            end
            OP_DISPATCH:
            begin
                for (int s = 0; s < SLOT_COUNT && n < MAX_RESULTS; s++)
                begin
                    if (tbl_active[s] && tbl_remaining[s] == '0)
                    begin
                        if (tbl_once[s])
                            tbl_active[s] = 1'b0;
                        tbl_remaining[s] = tbl_period[s];
                        fresh_results.push_back(make_result(s, 1, 0, 0));
                        n++;
                    end
                end
                if (n == 0)
                    fresh_results.push_back(make_result(0, 0, 0, 1));
                else
                begin
                    tail = fresh_results.pop_back();
                    tail.last = 1'b1;
                    fresh_results.push_back(tail);
                end
            end
            OP_CREATE_NEXT:
            begin
                if (tbl_next_free >= SLOT_COUNT)
                    fresh_results.push_back(make_result(0, 0, 1, 1));
                else
                begin
                    load_slot_model(tbl_next_free, r.period, r.act, r.once);
                    fresh_results.push_back(make_result(tbl_next_free, 0, 0, 1));
                    tbl_next_free++;
                end
            end
            OP_CREATE_ZERO:
            begin
                load_slot_model(0, r.period, r.act, r.once);
                fresh_results.push_back(make_result(0, 0, 0, 1));
            end
            OP_END:
            begin
                if (int'(r.slot) < SLOT_COUNT)
                    tbl_active[r.slot] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one item, wait for acceptance, then record what it should cause.
    task automatic offer_item(stim_row_t r);
        in_valid     <= 1'b1;
        operation    <= r.op;
        slot         <= r.slot;
        period       <= r.period;
        start_active <= r.act;
        one_shot     <= r.once;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_timer_table(r);
        if (r.has_fixed)
            pending_results.push_back(r.want);
        else
            foreach (fresh_results[i])
                pending_results.push_back(fresh_results[i]);
        items_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Random item: well-formed work on a live table, with some noise.
    function automatic stim_row_t random_row();
        stim_row_t r;
        int pick;
        int pk;
        r = stim_row(OP_TICK, $urandom_range(0, 7), $urandom(), $urandom_range(0, 1),
                     $urandom_range(0, 1), 0, 0, 0, 0, 0);
        pick = $urandom_range(0, 99);
        if (pick < 34)
            r.op = OP_TICK;
        else if (pick < 64)
            r.op = OP_DISPATCH;
        else if (pick < 78)
        begin
            // Slot zero is the only slot that can be brought back to life.
            r.op  = OP_CREATE_ZERO;
            r.act = ($urandom_range(0, 99) < 85);
            pk    = $urandom_range(0, 99);
            if (pk < 60)
                r.period = $urandom_range(0, 4);
            else if (pk < 85)
                r.period = $urandom_range(5, 20);
            else if (pk < 95)
                r.period = $urandom();
            else
                r.period = '1;
        end
        else if (pick < 84)
            r.op = OP_CREATE_NEXT;
        else if (pick < 92)
        begin
            // Ending slots 1 and up is permanent, so it is kept rare.
            r.op = OP_END;
            if ($urandom_range(0, 99) < 75)
                r.slot = 3'd0;
        end
        else
            r.op = OP_END + 3'($urandom_range(1, 3));
        return r;
    endfunction

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        timer_result_t got;
        timer_result_t want;
        got = make_result(handle, fired, status, last);
        results_seen++;
        if (got.fired === 1'b1)
            firings_seen++;
        if (got.status === 1'b1)
            full_seen++;
        if (pending_results.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("ERROR: unexpected result handle=%0d fired=%b status=%b last=%b",
                         got.handle, got.fired, got.status, got.last);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.handle !== want.handle || got.fired !== want.fired ||
                got.status !== want.status || got.last !== want.last)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("ERROR: result %0d expected handle=%0d fired=%b status=%b ",
                             results_seen, want.handle, want.fired, want.status,
                             "last=%b, got handle=%0d fired=%b status=%b last=%b",
                             want.last, got.handle, got.fired, got.status, got.last);
            end
        end
    endtask

    // Output side: check results and drive the stall pattern.
    initial
    begin
        int stall_left;
        bit long_hold_done;
        bit calm;
        stall_left = 0;
        long_hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            calm = ((cycle_count / 256) % 5) == 2;
            if (stall_left == 0)
            begin
                if (!long_hold_done && results_seen >= HOLD_AFTER)
                begin
                    long_hold_done = 1'b1;
                    stall_left = LONG_HOLD;
                end
                else if (!calm)
                    stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Input side: reset, directed table, random run, drain and verdict.
    initial
    begin
        int random_done;
        int n_directed;
        bit paused;
        stim_row_t r;

        random_done = 0;
        paused = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= OP_TICK;
        slot         <= '0;
        period       <= '0;
        start_active <= 1'b0;
        one_shot     <= 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++)
            load_slot_model(s, '0, 1'b0, 1'b0);
        tbl_next_free = 1;

        // Directed table: op, slot, period, active, one-shot, fixed?, result.
        directed_rows.push_back(stim_row(OP_DISPATCH, 0, 32'd0, 0, 0, 1, 0, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_TICK, 7, '1, 1, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd0, 1, 0, 1, 1, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd1, 1, 1, 1, 2, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 7, '1, 1, 0, 1, 3, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd2, 0, 0, 1, 4, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd3, 1, 0, 1, 5, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd1, 1, 0, 1, 6, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd2, 1, 1, 1, 7, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_CREATE_NEXT, 0, 32'd5, 1, 1, 1, 0, 0, 1, 1));
        directed_rows.push_back(stim_row(OP_CREATE_ZERO, 0, 32'd0, 1, 1, 1, 0, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_DISPATCH, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_TICK, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_DISPATCH, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_END, 4, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_END, 3, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_RSVD_5, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_RSVD_7, 7, '1, 1, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_TICK, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_TICK, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_DISPATCH, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_CREATE_ZERO, 0, 32'd2, 1, 0, 1, 0, 0, 0, 1));
        directed_rows.push_back(stim_row(OP_TICK, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_TICK, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(OP_DISPATCH, 0, 32'd0, 0, 0, 0, 0, 0, 0, 0));
        n_directed = directed_rows.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i]);
            idle_gap(pick_gap());
        end

        // Random run with one full drain in the middle.
        while (random_done < RANDOM_ITEMS)
        begin
            if (random_done == PAUSE_AT && !paused)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            r = random_row();
            offer_item(r);
            random_done++;
            if (random_done < CALM_FIRST || random_done >= CALM_LAST)
                idle_gap(pick_gap());
        end

        // Drain and let any late result show up.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d items (%0d directed), %0d results checked, %0d mismatches",
                 items_sent, n_directed, results_seen, mismatch_cnt);
        $display("Summary: %0d slot firings and %0d table-full replies in %0d cycles",
                 firings_seen, full_seen, cycle_count);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
